/* sv/nkts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nkts_pkg
// shared widths, types and register indexes of the nearest-k tile selector
// ----------------------------------------------------------------------------
package nkts_pkg;

    localparam int unsigned COORD_W   = 12;
    localparam int unsigned LAYER_W   = 8;
    localparam int unsigned CLASS_W   = 16;
    localparam int unsigned DIST_W    = 13;
    localparam int unsigned LIMIT_W   = 5;
    localparam int unsigned CCOUNT_W  = 3;
    localparam int unsigned CLIST_W   = 64;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned OUT_DATA_W = 48;

    // register indexes on the config channel
    localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_X    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_Y    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_Z    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LIMIT       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CLASS_COUNT = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_CLASS_LIST  = 3'd5;

    // input beat kinds (tuser)
    localparam logic KIND_TILE   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [DIST_W-1:0]  tile_dist;
    } t_entry;

    // what a cell shows its neighbors
    typedef struct packed {
        logic   valid;   // valid and inside the current limit
        logic   pass;    // kept entry is not farther than the new tile
        t_entry entry;
    } t_link;

    typedef struct packed {
        logic step;      // a beat was accepted: apply the limit
        logic ins;       // insert the new tile
        logic pop;       // shift toward the head for output
    } t_ctl;

endpackage

/* sv/nkts_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nkts_filter
// candidate check and manhattan distance of one incoming tile
// ----------------------------------------------------------------------------
module nkts_filter import nkts_pkg::*; #(
    parameter int unsigned CLASS_SLOTS = 4
) (
    input  logic [COORD_W-1:0]  i_tile_x,
    input  logic [COORD_W-1:0]  i_tile_y,
    input  logic [LAYER_W-1:0]  i_tile_z,
    input  logic [CLASS_W-1:0]  i_tile_class,
    input  logic                i_hidden,
    input  logic                i_already_marked,
    input  logic [COORD_W-1:0]  i_source_x,
    input  logic [COORD_W-1:0]  i_source_y,
    input  logic [LAYER_W-1:0]  i_source_z,
    input  logic [CCOUNT_W-1:0] i_class_count,
    input  logic [CLIST_W-1:0]  i_class_list,
    output logic                o_cand,
    output logic [DIST_W-1:0]   o_dist
);

    logic [CLASS_SLOTS-1:0] w_hit;
    logic [COORD_W-1:0]     w_dx;
    logic [COORD_W-1:0]     w_dy;

    // slots past class_count never match, which also saturates the count
    for (genvar g = 0; g < CLASS_SLOTS; g++) begin : g_slot
        assign w_hit[g] = (32'(i_class_count) > g) &&
                          (i_class_list[g*CLASS_W +: CLASS_W] == i_tile_class);
    end

    assign w_dx = (i_tile_x > i_source_x) ? i_tile_x - i_source_x : i_source_x - i_tile_x;
    assign w_dy = (i_tile_y > i_source_y) ? i_tile_y - i_source_y : i_source_y - i_tile_y;

    assign o_dist = {1'b0, w_dx} + {1'b0, w_dy};
    assign o_cand = (i_tile_z == i_source_z) && !i_hidden && !i_already_marked && (|w_hit);

endmodule

/* sv/nkts_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nkts_cell
// one slot of the sorted chain: holds a tile, shifts down on insert, up on pop
// ----------------------------------------------------------------------------
module nkts_cell import nkts_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,      // slot index is below the limit
    input  t_ctl   i_ctl,
    input  t_entry i_new,
    input  t_link  i_prev,
    input  t_link  i_next,
    output t_link  o_link
);

    logic   r_valid;
    t_entry r_entry;
    logic   w_vm;
    logic   w_pass;

    assign w_vm   = r_valid && i_en;
    assign w_pass = w_vm && (r_entry.tile_dist <= i_new.tile_dist);

    assign o_link.valid = w_vm;
    assign o_link.pass  = w_pass;
    assign o_link.entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.pop) begin
            r_valid <= i_next.valid;
        end else if (i_ctl.ins && !w_pass) begin
            r_valid <= i_en && (w_vm || i_prev.pass || i_prev.valid);
        end else if (i_ctl.step) begin
            r_valid <= w_vm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.pop) begin
            r_entry <= i_next.entry;
        end else if (i_ctl.ins && !w_pass) begin
            // first farther slot takes the tile, the rest take the neighbor
            r_entry <= i_prev.pass ? i_new : i_prev.entry;
        end
    end

endmodule

/* sv/nearest_k_tile_selector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_k_tile_selector
// keeps the nearest tiles to a source by manhattan distance, emits on finish
// ----------------------------------------------------------------------------
// A tile beat (tuser = 0) is taken back to back while no drain runs: it is checked
// against layer, visibility, mark and class list, and a candidate is inserted
// into a chain of CAPACITY cells kept sorted by ascending distance, where
// equal distances keep the earlier tile ahead and a full chain drops its
// farthest entry. A finish beat (tuser = 1) drops s_axis_tready and drains
// the chain nearest first through the output register, one result beat per
// cycle as the sink takes them; an empty chain yields a single beat with
// found = 0. Tile beats keep flowing while the final result still waits in
// the output register. The limit register caps how many cells are used; a
// lowered limit trims the chain at the next accepted beat. Config writes are
// always taken (cfg_ready is tied high) and belong only to idle periods.
// ----------------------------------------------------------------------------
module nearest_k_tile_selector import nkts_pkg::*; #(
    parameter int unsigned CAPACITY    = 16,
    parameter int unsigned CLASS_SLOTS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // tile stream in
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tile_x, tile_y, tile_z, tile_class, hidden, already_marked, zero pad
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // kind
    input  logic                  i_s_axis_tuser,
    // result stream out
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // out_x, out_y, out_z, distance, zero pad
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // found
    output logic                  o_m_axis_tuser,
    // last
    output logic                  o_m_axis_tlast
);

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } t_state;

    // config registers
    logic [COORD_W-1:0]  r_source_x;
    logic [COORD_W-1:0]  r_source_y;
    logic [LAYER_W-1:0]  r_source_z;
    logic [LIMIT_W-1:0]  r_limit;
    logic [CCOUNT_W-1:0] r_class_count;
    logic [CLIST_W-1:0]  r_class_list;

    // control and output register
    t_state              r_state;
    logic                r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic                r_m_found;
    logic                r_m_last;

    // input beat fields
    logic [COORD_W-1:0]  w_tile_x;
    logic [COORD_W-1:0]  w_tile_y;
    logic [LAYER_W-1:0]  w_tile_z;
    logic [CLASS_W-1:0]  w_tile_class;
    logic                w_hidden;
    logic                w_marked;

    logic                w_s_fire;
    logic                w_m_free;
    logic                w_cand;
    logic [DIST_W-1:0]   w_dist;
    t_entry              w_new;
    t_ctl                w_ctl;
    t_link               w_head;
    t_link               w_link [CAPACITY+1];

    assign w_tile_x     = i_s_axis_tdata[11:0];
    assign w_tile_y     = i_s_axis_tdata[23:12];
    assign w_tile_z     = i_s_axis_tdata[31:24];
    assign w_tile_class = i_s_axis_tdata[47:32];
    assign w_hidden     = i_s_axis_tdata[48];
    assign w_marked     = i_s_axis_tdata[49];

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_s_fire        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_m_free        = !r_m_valid || i_m_axis_tready;

    // config register file, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_x    <= '0;
            r_source_y    <= '0;
            r_source_z    <= '0;
            r_limit       <= LIMIT_RESET;
            r_class_count <= '0;
            r_class_list  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_addr)
                REG_SOURCE_X:    r_source_x    <= i_cfg_data[COORD_W-1:0];
                REG_SOURCE_Y:    r_source_y    <= i_cfg_data[COORD_W-1:0];
                REG_SOURCE_Z:    r_source_z    <= i_cfg_data[LAYER_W-1:0];
                REG_LIMIT:       r_limit       <= i_cfg_data[LIMIT_W-1:0];
                REG_CLASS_COUNT: r_class_count <= i_cfg_data[CCOUNT_W-1:0];
                REG_CLASS_LIST:  r_class_list  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    nkts_filter #(
        .CLASS_SLOTS (CLASS_SLOTS)
    ) u_filter (
        .i_tile_x         (w_tile_x),
        .i_tile_y         (w_tile_y),
        .i_tile_z         (w_tile_z),
        .i_tile_class     (w_tile_class),
        .i_hidden         (w_hidden),
        .i_already_marked (w_marked),
        .i_source_x       (r_source_x),
        .i_source_y       (r_source_y),
        .i_source_z       (r_source_z),
        .i_class_count    (r_class_count),
        .i_class_list     (r_class_list),
        .o_cand           (w_cand),
        .o_dist           (w_dist)
    );

    assign w_new.col       = w_tile_x;
    assign w_new.row       = w_tile_y;
    assign w_new.tile_dist = w_dist;

    // every accepted beat trims to the limit; drain pops the head when the
    // output register can take it
    assign w_ctl.step = w_s_fire;
    assign w_ctl.ins  = w_s_fire && (i_s_axis_tuser == KIND_TILE) && w_cand;
    assign w_ctl.pop  = (r_state == ST_DRAIN) && w_m_free && w_link[0].valid;

    // the head always lets the new tile in; the tail feeds empty slots on pop
    assign w_head.valid = 1'b0;
    assign w_head.pass  = 1'b1;
    assign w_head.entry = '0;

    assign w_link[CAPACITY].valid = 1'b0;
    assign w_link[CAPACITY].pass  = 1'b0;
    assign w_link[CAPACITY].entry = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        nkts_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (32'(r_limit) > g),
            .i_ctl   (w_ctl),
            .i_new   (w_new),
            .i_prev  ((g == 0) ? w_head : w_link[(g == 0) ? 0 : g-1]),
            .i_next  (w_link[g+1]),
            .o_link  (w_link[g])
        );
    end

    // drain sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            // during a drain the register is refilled whenever it frees up
            if (r_m_valid && i_m_axis_tready && (r_state == ST_IDLE)) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_s_fire && (i_s_axis_tuser == KIND_FINISH)) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (w_m_free) begin
                        r_m_valid <= 1'b1;
                        if (w_link[0].valid) begin
                            // nearest kept tile
                            r_m_data  <= {3'b000, w_link[0].entry.tile_dist, r_source_z,
                                          w_link[0].entry.row, w_link[0].entry.col};
                            r_m_found <= 1'b1;
                            r_m_last  <= !w_link[1].valid;
                            if (!w_link[1].valid) begin
                                r_state <= ST_IDLE;
                            end
                        end else begin
                            // nothing kept: single empty answer
                            r_m_data  <= '0;
                            r_m_found <= 1'b0;
                            r_m_last  <= 1'b1;
                            r_state   <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_found;
    assign o_m_axis_tlast  = r_m_last;

endmodule

/* sv/nkts_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nkts_checker
// port-level checks of the nearest-k tile selector, bound to the top level
// ----------------------------------------------------------------------------
module nkts_checker import nkts_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic                  i_s_axis_tuser,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic                  o_m_axis_tuser,
    input logic                  o_m_axis_tlast
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result beat changed while stalled");

    // an empty answer is all zero and closes the run
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tlast && (o_m_axis_tdata == '0))
        else $error("empty answer not a zero last beat");

    // an accepted finish beat stops input
    a_finish_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == KIND_FINISH)
            |=> !o_s_axis_tready)
        else $error("input still ready after finish beat");

    // input stays blocked while results of a finish are still to come
    a_drain_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> !o_s_axis_tready)
        else $error("input ready in the middle of a run");

endmodule

bind nearest_k_tile_selector nkts_checker u_nkts_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
